// ----- rtl/smvlq_pkg.sv -----
// Package for the source-map segment VLQ encoder.
// Holds widths, character codes, sequencer states and the base64 digit function.
// Depends on nothing.
`default_nettype none

package smvlq_pkg;

  localparam int SOURCE_BITS = 16;
  localparam int LINE_BITS   = 24;
  localparam int VAL_BITS    = (SOURCE_BITS > LINE_BITS) ? SOURCE_BITS : LINE_BITS;
  localparam int CODE_BITS   = (VAL_BITS + 1 > 6) ? VAL_BITS + 1 : 6;
  localparam int DIGIT_BITS  = 5;
  localparam int CHAR_BITS   = 7;

  localparam logic [CHAR_BITS-1:0] CHAR_A    = 7'h41;
  localparam logic [CHAR_BITS-1:0] CHAR_LC_A = 7'h61;
  localparam logic [CHAR_BITS-1:0] CHAR_ZERO = 7'h30;
  localparam logic [CHAR_BITS-1:0] CHAR_PLUS = 7'h2b;
  localparam logic [CHAR_BITS-1:0] CHAR_SLSH = 7'h2f;
  localparam logic [CHAR_BITS-1:0] CHAR_SEMI = 7'h3b;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GEN_COL,
    ST_SRC,
    ST_LINE,
    ST_SRC_COL,
    ST_SEMI
  } state_t;

  typedef struct packed {
    logic load;
    logic shift;
  } unit_ctrl_t;

  typedef struct packed {
    logic [DIGIT_BITS:0] digit;
    logic                more;
  } unit_stat_t;

  function automatic logic [CHAR_BITS-1:0] b64_char(input logic [DIGIT_BITS:0] d);
    logic [CHAR_BITS-1:0] dx;
    dx = CHAR_BITS'(d);
    if (d < 6'd26) begin
      return CHAR_A + dx;
    end else if (d < 6'd52) begin
      return CHAR_LC_A + dx - 7'd26;
    end else if (d < 6'd62) begin
      return CHAR_ZERO + dx - 7'd52;
    end else if (d == 6'd62) begin
      return CHAR_PLUS;
    end else begin
      return CHAR_SLSH;
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/smvlq_unit.sv -----
// Shared VLQ unit: forms the sign-in-low-bit code of a delta and shifts out 5-bit digits.
// Depends on smvlq_pkg.
`default_nettype none

module smvlq_unit (
  input  wire logic                         clk,
  input  wire smvlq_pkg::unit_ctrl_t        ctrl,
  input  wire logic [smvlq_pkg::VAL_BITS-1:0] cur,
  input  wire logic [smvlq_pkg::VAL_BITS-1:0] prev,
  output smvlq_pkg::unit_stat_t             stat
);

  logic [smvlq_pkg::CODE_BITS-1:0] code_r;
  logic [smvlq_pkg::CODE_BITS-1:0] code_nxt;
  logic [smvlq_pkg::VAL_BITS-1:0]  mag;
  logic                            neg;
  logic                            more;

  always_comb begin
    neg = (cur < prev);
    mag = neg ? (prev - cur) : (cur - prev);
    code_nxt = code_r;
    if (ctrl.load) begin
      code_nxt = smvlq_pkg::CODE_BITS'({mag, neg});
    end else if (ctrl.shift) begin
      code_nxt = code_r >> smvlq_pkg::DIGIT_BITS;
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
  end

  assign more = |code_r[smvlq_pkg::CODE_BITS-1:smvlq_pkg::DIGIT_BITS];
  assign stat = {{more, code_r[smvlq_pkg::DIGIT_BITS-1:0]}, more};

endmodule

`default_nettype wire

// ----- rtl/source_map_segment_vlq_encoder.sv -----
// Top level of the source-map segment encoder: sequencer, stored index and line, output register.
// Depends on smvlq_pkg and smvlq_unit.
// On an accepted request the sequencer enters its generated-column state; the output register
// then takes the first character. One character per cycle while out_ready allows; a segment
// is 5 to 12 characters, and a new request is taken only in idle, after the segment's end.
// Reset clears the previous source index and line to zero and empties the output register.
`default_nettype none

module source_map_segment_vlq_encoder (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [smvlq_pkg::SOURCE_BITS-1:0] in_source_index,
  input  wire logic [smvlq_pkg::LINE_BITS-1:0]   in_source_line,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [smvlq_pkg::CHAR_BITS-1:0]        out_character,
  output logic                                   out_last
);

  smvlq_pkg::state_t state_r;
  smvlq_pkg::state_t state_nxt;

  logic [smvlq_pkg::SOURCE_BITS-1:0] src_r;
  logic [smvlq_pkg::LINE_BITS-1:0]   lin_r;
  logic [smvlq_pkg::SOURCE_BITS-1:0] prev_src_r;
  logic [smvlq_pkg::LINE_BITS-1:0]   prev_lin_r;

  logic                              out_valid_r;
  logic [smvlq_pkg::CHAR_BITS-1:0]   out_character_r;
  logic                              out_last_r;

  logic                              adv;
  logic                              sel_line;
  logic                              upd_prev;
  logic [smvlq_pkg::CHAR_BITS-1:0]   ch;
  logic                              ch_last;
  logic [smvlq_pkg::VAL_BITS-1:0]    u_cur;
  logic [smvlq_pkg::VAL_BITS-1:0]    u_prev;
  smvlq_pkg::unit_ctrl_t             u_ctrl;
  smvlq_pkg::unit_stat_t             u_stat;

  assign in_ready      = (state_r == smvlq_pkg::ST_IDLE);
  assign adv           = (state_r != smvlq_pkg::ST_IDLE) && (!out_valid_r || out_ready);
  assign sel_line      = (state_r == smvlq_pkg::ST_SRC);
  assign u_cur         = sel_line ? smvlq_pkg::VAL_BITS'(lin_r) : smvlq_pkg::VAL_BITS'(src_r);
  assign u_prev        = sel_line ? smvlq_pkg::VAL_BITS'(prev_lin_r)
                                  : smvlq_pkg::VAL_BITS'(prev_src_r);
  assign out_valid     = out_valid_r;
  assign out_character = out_character_r;
  assign out_last      = out_last_r;

  smvlq_unit u_unit (
    .clk  (clk),
    .ctrl (u_ctrl),
    .cur  (u_cur),
    .prev (u_prev),
    .stat (u_stat)
  );

  always_comb begin
    state_nxt = state_r;
    u_ctrl    = '0;
    ch        = smvlq_pkg::CHAR_A;
    ch_last   = 1'b0;
    upd_prev  = 1'b0;
    unique case (state_r)
      smvlq_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = smvlq_pkg::ST_GEN_COL;
        end
      end
      smvlq_pkg::ST_GEN_COL: begin
        if (adv) begin
          u_ctrl.load = 1'b1;
          state_nxt   = smvlq_pkg::ST_SRC;
        end
      end
      smvlq_pkg::ST_SRC: begin
        ch = smvlq_pkg::b64_char(u_stat.digit);
        if (adv) begin
          if (u_stat.more) begin
            u_ctrl.shift = 1'b1;
          end else begin
            u_ctrl.load = 1'b1;
            state_nxt   = smvlq_pkg::ST_LINE;
          end
        end
      end
      smvlq_pkg::ST_LINE: begin
        ch = smvlq_pkg::b64_char(u_stat.digit);
        if (adv) begin
          if (u_stat.more) begin
            u_ctrl.shift = 1'b1;
          end else begin
            state_nxt = smvlq_pkg::ST_SRC_COL;
          end
        end
      end
      smvlq_pkg::ST_SRC_COL: begin
        if (adv) begin
          state_nxt = smvlq_pkg::ST_SEMI;
        end
      end
      smvlq_pkg::ST_SEMI: begin
        ch      = smvlq_pkg::CHAR_SEMI;
        ch_last = 1'b1;
        if (adv) begin
          upd_prev  = 1'b1;
          state_nxt = smvlq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = smvlq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= smvlq_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      prev_src_r  <= '0;
      prev_lin_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (upd_prev) begin
        prev_src_r <= src_r;
        prev_lin_r <= lin_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      src_r <= in_source_index;
      lin_r <= in_source_line;
    end
    if (adv) begin
      out_character_r <= ch;
      out_last_r      <= ch_last;
    end
  end

  // The closing character of a segment is always the semicolon.
  a_last_is_semi: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> out_character_r == smvlq_pkg::CHAR_SEMI)
    else $error("segment end flagged on a character other than the semicolon");

  // An accepted request starts with the generated-column character.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == smvlq_pkg::ST_GEN_COL)
    else $error("sequencer did not start a segment after a request");

  // Leaving the final state places the segment end in the output register.
  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == smvlq_pkg::ST_SEMI && adv |=>
      state_r == smvlq_pkg::ST_IDLE && out_valid_r && out_last_r)
    else $error("segment end not presented when the sequencer returned to idle");

endmodule

`default_nettype wire
